/* rtl/tcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, constants and helpers of the text console scrollback core.
// ----------------------------------------------------------------------------
package tcs_pkg;

   // console geometry
   localparam int COLUMNS      = 80;
   localparam int VISIBLE_ROWS = 25;
   localparam int HISTORY_ROWS = 125;

   localparam int ROW_W  = $clog2(HISTORY_ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CELLS  = HISTORY_ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CELL_W = 16;
   localparam int BACK_ROWS = (VISIBLE_ROWS - 1) % HISTORY_ROWS;

   // character and cell codes
   localparam logic [7:0]        NEWLINE_CODE    = 8'd10;
   localparam logic [CELL_W-1:0] BLANK_CELL      = 16'h0720;
   localparam logic [7:0]        RESET_ATTRIBUTE = 8'd15;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_DEFAULT_ATTR = 1'b0;

   typedef enum logic [1:0] {
      FUNC_PUT       = 2'd0,
      FUNC_VIEW_UP   = 2'd1,
      FUNC_VIEW_DOWN = 2'd2,
      FUNC_READ      = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_code;
      logic [7:0] attribute;
      logic       use_default;
      logic [4:0] view_line;
      logic [6:0] view_column;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_entry;
      logic [6:0]  write_row;
      logic [6:0]  write_column;
      logic [6:0]  view_top;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic clear;
      logic capture;
   } tcs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic advance;
      logic read_hit;
      logic clear_last;
   } tcs_sts_type;

   // view top that puts the given row on the bottom visible line
   function automatic logic [ROW_W-1:0] bottom_aligned_top(input logic [ROW_W-1:0] row);
      logic [ROW_W:0] sum;
      sum = {1'b0, row} + (ROW_W+1)'(HISTORY_ROWS - BACK_ROWS);
      if (sum >= (ROW_W+1)'(HISTORY_ROWS)) begin
         sum = sum - (ROW_W+1)'(HISTORY_ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

endpackage

/* rtl/text_console_scrollback_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_scrollback_core
// Text console with a ring of scrollback rows, 16-bit character cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// rsp_data for exactly one cycle with rsp_valid high, and the receiver must
// take it then. A view move, a plain character put or a read outside the
// visible window gives its result after the execute state, a read inside
// the window after the execute and read states. A newline, or a put into
// the last column, clears the next ring row through the single port of the
// cell memory one cell per cycle, so that result comes after the clear
// sweep. busy drops in the cycle the result shows, so the next request can
// follow at once. After reset the core is busy while it clears the first
// write row; rows never written since reset read as light-grey blanks.
// Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_scrollback_core import tcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   tcs_cmd_type cmd;
   tcs_sts_type sts;
   logic [7:0]  default_attr_ff;
   logic        csr_wr;
   logic        csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == CSR_IDX_DEFAULT_ATTR);
   assign csr_wr  = psel && penable && pwrite && csr_hit;
   assign prdata  = csr_hit ? {24'd0, default_attr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= RESET_ATTRIBUTE;
      end else if (csr_wr) begin
         default_attr_ff <= pwdata[7:0];
      end
   end

   tcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   tcs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_data     (req_data),
      .default_attr (default_attr_ff),
      .rsp_data     (rsp_data)
   );

endmodule

/* rtl/tcs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/tcs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer of the console: request intake, row clear sweeps, read wait.
// ----------------------------------------------------------------------------
module tcs_ctrl import tcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output tcs_cmd_type cmd,
   input  tcs_sts_type sts
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_READ
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_INIT: begin
               // row 0 is the first write row and needs a clean start
               if (sts.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (sts.advance) begin
                  state_ff <= ST_CLEAR;
               end else if (sts.read_hit) begin
                  state_ff <= ST_READ;
               end else begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_CLEAR: begin
               if (sts.clear_last) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_READ: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_INIT;
            end
         endcase
      end
   end

   always_comb begin
      cmd.load    = (state_ff == ST_IDLE) && start;
      cmd.exec    = (state_ff == ST_EXEC);
      cmd.clear   = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);
      cmd.capture = (state_ff == ST_READ);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/tcs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_datapath
// Cursor, view top, row valid bits and the cell store of the console.
// ----------------------------------------------------------------------------
module tcs_datapath import tcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tcs_cmd_type cmd,
   output tcs_sts_type sts,
   input  req_type     req_data,
   input  logic [7:0]  default_attr,
   output rsp_type     rsp_data
);

   req_type               req_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      top_ff;
   logic [HISTORY_ROWS-1:0] valid_ff;
   logic [COL_W-1:0]      clr_cnt_ff;
   logic [CELL_W-1:0]     entry_ff;
   logic                  rd_valid_ff;

   logic                  is_put;
   logic                  is_newline;
   logic                  col_last;
   logic                  in_window;
   logic [ROW_W-1:0]      following_row;
   logic [ROW_W:0]        rd_sum;
   logic [ROW_W-1:0]      rd_row;
   logic [7:0]            put_attr;
   logic [ADDR_W-1:0]     cursor_addr;
   logic [ADDR_W-1:0]     clear_addr;
   logic [ADDR_W-1:0]     read_addr;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_addr;
   logic [CELL_W-1:0]     ram_wdata;
   logic [CELL_W-1:0]     ram_rdata;

   always_comb begin
      is_put     = (func_type'(req_ff.func) == FUNC_PUT);
      is_newline = (req_ff.char_code == NEWLINE_CODE);
      col_last   = (col_ff == COL_W'(COLUMNS - 1));
      following_row = (row_ff == ROW_W'(HISTORY_ROWS - 1)) ? '0 : row_ff + 1'b1;
      in_window  = (32'(req_ff.view_line) < VISIBLE_ROWS) &&
                   (32'(req_ff.view_column) < COLUMNS);
      // top plus line stays below twice the ring length
      rd_sum = {1'b0, top_ff} + (ROW_W+1)'(req_ff.view_line);
      if (rd_sum >= (ROW_W+1)'(HISTORY_ROWS)) begin
         rd_sum = rd_sum - (ROW_W+1)'(HISTORY_ROWS);
      end
      rd_row   = rd_sum[ROW_W-1:0];
      put_attr = req_ff.use_default ? default_attr : req_ff.attribute;

      cursor_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
      clear_addr  = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(clr_cnt_ff);
      read_addr   = ADDR_W'(rd_row) * ADDR_W'(COLUMNS) + ADDR_W'(req_ff.view_column);
   end

   always_comb begin
      sts.advance    = is_put && (is_newline || col_last);
      sts.read_hit   = (func_type'(req_ff.func) == FUNC_READ) && in_window;
      sts.clear_last = (clr_cnt_ff == COL_W'(COLUMNS - 1));
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = cursor_addr;
      ram_wdata = {put_attr, req_ff.char_code};
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_addr  = clear_addr;
         ram_wdata = BLANK_CELL;
      end else if (cmd.exec) begin
         if (is_put && !is_newline) begin
            ram_we = 1'b1;
         end else if (func_type'(req_ff.func) == FUNC_READ) begin
            ram_addr = read_addr;
         end
      end
   end

   tcs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         top_ff     <= bottom_aligned_top('0);
         valid_ff   <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.exec) begin
            case (func_type'(req_ff.func))
               FUNC_PUT: begin
                  if (is_newline || col_last) begin
                     row_ff <= following_row;
                     col_ff <= '0;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                     top_ff <= bottom_aligned_top(row_ff);
                  end
               end
               FUNC_VIEW_UP: begin
                  top_ff <= (top_ff == '0) ? ROW_W'(HISTORY_ROWS - 1) : top_ff - 1'b1;
               end
               FUNC_VIEW_DOWN: begin
                  top_ff <= (top_ff == ROW_W'(HISTORY_ROWS - 1)) ? '0 : top_ff + 1'b1;
               end
               default: begin
               end
            endcase
         end
         if (cmd.clear) begin
            if (sts.clear_last) begin
               clr_cnt_ff       <= '0;
               valid_ff[row_ff] <= 1'b1;
               top_ff           <= bottom_aligned_top(row_ff);
            end else begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         entry_ff    <= '0;
         rd_valid_ff <= valid_ff[rd_row];
      end
      if (cmd.capture) begin
         // rows never cleared since reset still read as blanks
         entry_ff <= rd_valid_ff ? ram_rdata : BLANK_CELL;
      end
   end

   always_comb begin
      rsp_data.cell_entry   = entry_ff;
      rsp_data.write_row    = 7'(row_ff);
      rsp_data.write_column = 7'(col_ff);
      rsp_data.view_top     = 7'(top_ff);
   end

endmodule
